// ===== hdl/spwt_pkg.sv =====
// Shared types and constants for the serial pattern wait with timeout block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package spwt_pkg;

	localparam int PATTERN_MAX = 16;
	localparam int PAT_BYTES   = 16;
	localparam int LEN_CAP     = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
	localparam int FILL_W      = $clog2(PATTERN_MAX + 1);
	localparam int PAT_IDX_W   = $clog2(PAT_BYTES);

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_ARM  = 2'd2;

	localparam logic [1:0] REG_PAT_LO  = 2'd0;
	localparam logic [1:0] REG_PAT_HI  = 2'd1;
	localparam logic [1:0] REG_PAT_LEN = 2'd2;
	localparam logic [1:0] REG_TIMEOUT = 2'd3;

	localparam logic [7:0] CTRL_LIMIT = 8'h10;
	localparam logic [7:0] IDLE_MAX   = 8'hFF;

	localparam logic OUTCOME_MATCH   = 1'b0;
	localparam logic OUTCOME_TIMEOUT = 1'b1;

	typedef enum logic [1:0] {
		OP_BYTE,
		OP_TICK,
		OP_ARM,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic             full;
		logic             empty;
		logic [QCW-1:0]   count;
	} qstat_t;

endpackage

// ===== hdl/spwt_front.sv =====
// Front end: accepts input items, decodes the kind and drops unused codes.
// Depends on spwt_pkg; feeds spwt_queue.
module spwt_front (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [7:0]        data,
	input  spwt_pkg::qstat_t  qstat,
	output logic              push,
	output spwt_pkg::item_t   item
);
	import spwt_pkg::*;

	op_t op;

	always_comb begin
		unique case (kind)
			KIND_BYTE: op = OP_BYTE;
			KIND_TICK: op = OP_TICK;
			KIND_ARM:  op = OP_ARM;
			default:   op = OP_NONE;
		endcase
	end

	assign in_stall  = qstat.full;
	assign push      = in_valid && !qstat.full && (op != OP_NONE);
	assign item.op   = op;
	assign item.data = data;

endmodule

// ===== hdl/spwt_queue.sv =====
// Short item queue between front and back ends.
// Depends on spwt_pkg.
module spwt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  spwt_pkg::item_t   push_item,
	input  logic              pop,
	output spwt_pkg::item_t   head,
	output spwt_pkg::qstat_t  qstat
);
	import spwt_pkg::*;

	item_t           mem_q [QDEPTH];
	logic [QAW-1:0]  wr_q;
	logic [QAW-1:0]  rd_q;
	logic [QCW-1:0]  cnt_q;
	logic            do_push;
	logic            do_pop;

	assign qstat.full  = (cnt_q == QCW'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign qstat.count = cnt_q;
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QAW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == QAW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

// ===== hdl/spwt_back.sv =====
// Back end: configuration registers, byte window, idle counter and result register.
// Depends on spwt_pkg; drains spwt_queue.
module spwt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  spwt_pkg::item_t   item,
	input  logic              avail,
	output logic              pop,
	input  logic              cfg_valid,
	input  logic [1:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              outcome
);
	import spwt_pkg::*;

	logic [63:0]          pat_lo_q;
	logic [63:0]          pat_hi_q;
	logic [4:0]           pat_len_q;
	logic [7:0]           timeout_q;
	logic [7:0]           win_q [PATTERN_MAX];
	logic [7:0]           win_new [PATTERN_MAX];
	logic [FILL_W-1:0]    fill_q;
	logic [FILL_W-1:0]    fill_inc;
	logic [7:0]           idle_q;
	logic [7:0]           idle_inc;
	logic                 armed_q;
	logic                 out_valid_q;
	logic                 outcome_q;
	logic [4:0]           eff_len;
	logic [8*PAT_BYTES-1:0] pat_vec;
	logic                 match;
	logic                 hit;
	logic                 res_fire;

	assign pop      = avail && (!out_valid_q || !out_stall);
	assign pat_vec  = {pat_hi_q, pat_lo_q};
	assign fill_inc = (fill_q < FILL_W'(PATTERN_MAX)) ? fill_q + 1'b1 : fill_q;
	assign idle_inc = (idle_q < IDLE_MAX) ? idle_q + 1'b1 : idle_q;
	assign hit      = (idle_inc >= timeout_q);

	always_comb begin
		eff_len = (pat_len_q == '0) ? 5'd1 : pat_len_q;
		if (eff_len > 5'(LEN_CAP)) begin
			eff_len = 5'(LEN_CAP);
		end
	end

	always_comb begin
		win_new[0] = item.data;
		for (int i = 1; i < PATTERN_MAX; i++) begin
			win_new[i] = win_q[i-1];
		end
	end

	always_comb begin
		logic [PAT_IDX_W-1:0] idx;
		idx   = '0;
		match = (fill_inc >= FILL_W'(eff_len));
		for (int j = 0; j < LEN_CAP; j++) begin
			idx = PAT_IDX_W'(eff_len - 5'd1 - 5'(j));
			if ((5'(j) < eff_len) && (win_new[j] != pat_vec[8*idx +: 8])) begin
				match = 1'b0;
			end
		end
	end

	assign res_fire = pop && armed_q &&
	                  (((item.op == OP_BYTE) && match) || ((item.op == OP_TICK) && hit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q    <= '0;
			pat_hi_q    <= '0;
			pat_len_q   <= 5'd1;
			timeout_q   <= 8'd3;
			fill_q      <= '0;
			idle_q      <= '0;
			armed_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_PAT_LO:  pat_lo_q  <= cfg_data;
					REG_PAT_HI:  pat_hi_q  <= cfg_data;
					REG_PAT_LEN: pat_len_q <= cfg_data[4:0];
					REG_TIMEOUT: timeout_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			out_valid_q <= res_fire || (out_valid_q && out_stall);
			if (pop) begin
				unique case (item.op)
					OP_ARM: begin
						fill_q  <= '0;
						idle_q  <= '0;
						armed_q <= 1'b1;
					end
					OP_BYTE: begin
						if (armed_q) begin
							idle_q <= '0;
							if (match) begin
								armed_q <= 1'b0;
								fill_q  <= fill_inc;
							end else if (item.data < CTRL_LIMIT) begin
								fill_q <= '0;
							end else begin
								fill_q <= fill_inc;
							end
						end
					end
					OP_TICK: begin
						if (armed_q) begin
							idle_q <= idle_inc;
							if (hit) begin
								armed_q <= 1'b0;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && armed_q && (item.op == OP_BYTE)) begin
			win_q <= win_new;
		end
		if (res_fire) begin
			outcome_q <= (item.op == OP_TICK) ? OUTCOME_TIMEOUT : OUTCOME_MATCH;
		end
	end

	assign out_valid = out_valid_q;
	assign outcome   = outcome_q;

endmodule

// ===== hdl/serial_pattern_wait_with_timeout_core.sv =====
// Top level of the serial pattern wait with timeout block.
// Depends on spwt_pkg, spwt_front, spwt_queue and spwt_back.
//
// Input channel (in_valid/in_stall, kind, data): received bytes, timer ticks
// and arm items. An arm item starts a wait with an empty window and idle count.
// While armed, a byte whose arrival completes the configured pattern yields a
// match result; enough ticks without a byte yield a timeout result. Both
// results disarm the block. Unused kinds are taken and dropped.
// Output channel (out_valid/out_stall, outcome): 0 match, 1 timeout.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always
// ready; write only while no item is in flight.
// Throughput: one item per cycle while the queue is not full and no result
// waits on a receiver stall. An accepted item is written into the four-entry
// queue and the result register loads as it leaves. The compare of up to 16
// window bytes against the pattern is combinational in the back end.
// Reset: control state, queue and configuration registers return to their
// defaults at once, the block is disarmed and the input is accepted in the
// first cycle. Receiver stall: the result register holds; the queue absorbs
// up to four items, then in_stall rises until the result is taken.
module serial_pattern_wait_with_timeout_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        outcome,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import spwt_pkg::*;

	qstat_t qstat;
	item_t  push_item;
	item_t  head;
	logic   push;
	logic   pop;

	assign cfg_ready = 1'b1;

	spwt_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.data     (data),
		.qstat    (qstat),
		.push     (push),
		.item     (push_item)
	);

	spwt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	spwt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (head),
		.avail     (!qstat.empty),
		.pop       (pop),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.outcome   (outcome)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (qstat.count == QCW'($past(qstat.count) + 1'b1)))
		else $error("queue count did not advance on push");

	a_result_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pop))
		else $error("result without a drained item");

endmodule

// ===== tb/serial_pattern_wait_with_timeout_core_tb.sv =====
// Self-checking bench for serial_pattern_wait_with_timeout_core: random and directed
// bytes, ticks and arm items across several pattern and timeout settings.
// Depends on spwt_pkg and the core RTL only.
module serial_pattern_wait_with_timeout_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spwt_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int NUM_ROUNDS    = 12;
	localparam int ROUND_ITEMS   = 75;
	localparam int SETTLE_CYCLES = 20;
	localparam int MAX_REPORTS   = 20;
	localparam int TICK_CAP      = 24;
	localparam longint LIMIT_NS  = 5_000_000;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] data;
	} serial_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = KIND_BYTE;
	logic [7:0]  data = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        outcome;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_PAT_LO;
	logic [63:0] cfg_data = 64'd0;

	serial_item_t pending_items[$];
	serial_item_t next_item;
	logic         expected_outcomes[$];
	logic         in_accepted = 1'b0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           items_sent = 0;
	int           items_taken = 0;
	int           mismatch_count = 0;
	int           matches_seen = 0;
	int           timeouts_seen = 0;

	// predicted state of the wait
	logic [63:0] pat_lo = 64'd0;
	logic [63:0] pat_hi = 64'd0;
	logic [4:0]  pat_len = 5'd1;
	logic [7:0]  tmo_ticks = 8'd3;
	logic [7:0]  window [PATTERN_MAX];
	int          fill_count = 0;
	int          idle_ticks = 0;
	bit          armed = 1'b0;
	logic        next_outcome;

	// stimulus generator view of the current setting
	logic [7:0]  gen_pat [16];
	int          gen_len = 1;
	int          gen_tmo = 3;

	serial_pattern_wait_with_timeout_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.data(data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.outcome(outcome),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit predict_wait(input logic [1:0] k, input logic [7:0] d,
			output logic oc);
		int  len;
		int  j;
		bit  hit;
		logic [7:0] pb;
		oc = OUTCOME_MATCH;
		if (k == KIND_ARM) begin
			fill_count = 0;
			idle_ticks = 0;
			armed = 1'b1;
			return 1'b0;
		end
		if (!armed)
			return 1'b0;
		if (k == KIND_BYTE) begin
			for (j = PATTERN_MAX - 1; j > 0; j--)
				window[j] = window[j - 1];
			window[0] = d;
			if (fill_count < PATTERN_MAX)
				fill_count++;
			idle_ticks = 0;
			len = (pat_len == 0) ? 1 : pat_len;
			if (len > LEN_CAP)
				len = LEN_CAP;
			hit = (fill_count >= len);
			for (j = 0; j < len; j++) begin
				pb = (j < 8) ? pat_lo[8*j +: 8] : pat_hi[8*(j-8) +: 8];
				if (window[len - 1 - j] != pb)
					hit = 1'b0;
			end
			if (hit) begin
				armed = 1'b0;
				return 1'b1;
			end
			if (d < CTRL_LIMIT)
				fill_count = 0;
			return 1'b0;
		end
		if (k == KIND_TICK) begin
			if (idle_ticks < IDLE_MAX)
				idle_ticks++;
			if (idle_ticks >= tmo_ticks) begin
				armed = 1'b0;
				oc = OUTCOME_TIMEOUT;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic add_item(input logic [1:0] k, input logic [7:0] d);
		serial_item_t it;
		it.kind = k;
		it.data = d;
		pending_items.push_back(it);
		items_sent++;
	endtask

	task automatic add_wait_sequence();
		int sel;
		int n;
		int i;
		int cut;
		sel = $urandom_range(99);
		if (sel < 45) begin
			add_item(KIND_ARM, 8'($urandom_range(255)));
			n = $urandom_range(3);
			repeat (n) add_item(KIND_BYTE, 8'($urandom_range(8'h10, 8'hFF)));
			for (i = 0; i < gen_len; i++) begin
				if ($urandom_range(9) == 0)
					add_item(KIND_TICK, 8'($urandom_range(255)));
				add_item(KIND_BYTE, gen_pat[i]);
			end
		end else if (sel < 70) begin
			add_item(KIND_ARM, 8'($urandom_range(255)));
			n = $urandom_range(2);
			repeat (n) add_item(KIND_BYTE, 8'($urandom_range(255)));
			n = gen_tmo + $urandom_range(1);
			if (n == 0)
				n = 1;
			if (n > TICK_CAP)
				n = TICK_CAP;
			repeat (n) add_item(KIND_TICK, 8'($urandom_range(255)));
		end else if (sel < 85) begin
			add_item(KIND_ARM, 8'($urandom_range(255)));
			cut = $urandom_range(gen_len - 1);
			for (i = 0; i < cut; i++)
				add_item(KIND_BYTE, gen_pat[i]);
			if ($urandom_range(1))
				add_item(KIND_BYTE, 8'($urandom_range(8'h0F)));
			else
				add_item(KIND_BYTE, 8'($urandom_range(255)));
			for (i = cut; i < gen_len; i++)
				add_item(KIND_BYTE, gen_pat[i]);
		end else begin
			n = $urandom_range(1, 6);
			repeat (n) add_item(2'($urandom_range(3)), 8'($urandom_range(255)));
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (items_taken != items_sent || expected_outcomes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// advance to the next item once the current one is taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_accepted)) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = pending_items.pop_front();
				in_valid <= 1'b1;
				kind <= next_item.kind;
				data <= next_item.data;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_accepted <= 1'b0;
		end else begin
			in_accepted <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				if (outcome === OUTCOME_MATCH)
					matches_seen++;
				else
					timeouts_seen++;
				if (expected_outcomes.size() == 0) begin
					if (mismatch_count < MAX_REPORTS)
						$display("%0t: unexpected result, expected none, actual outcome %0b",
							$time, outcome);
					mismatch_count++;
				end else if (outcome !== expected_outcomes[0]) begin
					if (mismatch_count < MAX_REPORTS)
						$display("%0t: outcome mismatch, expected %0b, actual %0b",
							$time, expected_outcomes[0], outcome);
					mismatch_count++;
					void'(expected_outcomes.pop_front());
				end else begin
					void'(expected_outcomes.pop_front());
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PAT_LO:  pat_lo = cfg_data;
					REG_PAT_HI:  pat_hi = cfg_data;
					REG_PAT_LEN: pat_len = cfg_data[4:0];
					REG_TIMEOUT: tmo_ticks = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				items_taken++;
				if (predict_wait(kind, data, next_outcome))
					expected_outcomes.push_back(next_outcome);
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

	initial begin
		int r;
		int i;
		int round_start;
		int len_raw;
		int tmo_raw;
		logic [63:0] lo;
		logic [63:0] hi;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 24;
		recv_stall_pct = 49;

		// default setting: one pattern byte of zero, timeout after three ticks
		add_item(KIND_BYTE, 8'h00);
		add_item(KIND_TICK, 8'hFF);
		add_item(KIND_UNUSED, 8'hFF);
		add_item(KIND_ARM, 8'h00);
		add_item(KIND_TICK, 8'h00);
		add_item(KIND_TICK, 8'h00);
		add_item(KIND_TICK, 8'h00);
		add_item(KIND_TICK, 8'h00);
		add_item(KIND_ARM, 8'hAA);
		add_item(KIND_BYTE, 8'hFF);
		add_item(KIND_BYTE, 8'h80);
		add_item(KIND_BYTE, 8'h00);
		add_item(KIND_ARM, 8'h55);
		add_item(KIND_TICK, 8'h00);
		add_item(KIND_TICK, 8'h00);
		add_item(KIND_ARM, 8'h00);
		add_item(KIND_UNUSED, 8'h00);
		add_item(KIND_TICK, 8'h00);
		add_item(KIND_TICK, 8'h00);
		add_item(KIND_BYTE, 8'h05);
		add_item(KIND_TICK, 8'h00);
		add_item(KIND_TICK, 8'h00);
		add_item(KIND_BYTE, 8'h00);

		for (r = 1; r <= NUM_ROUNDS; r++) begin
			wait_idle();
			if (r == 5) begin
				send_idle_pct = 49;
				recv_stall_pct = 24;
			end else if (r == 9) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			for (i = 0; i < 16; i++)
				gen_pat[i] = r[0] ? 8'($urandom_range(8'h10, 8'hFF)) : 8'($urandom_range(255));
			case (r)
				1: begin
					for (i = 0; i < 16; i++)
						gen_pat[i] = 8'h00;
					len_raw = 0;
					tmo_raw = 0;
				end
				2: begin
					for (i = 0; i < 16; i++)
						gen_pat[i] = 8'hFF;
					len_raw = 31;
					tmo_raw = 1;
				end
				3: begin
					len_raw = 16;
					tmo_raw = 255;
				end
				4: begin
					len_raw = 1;
					tmo_raw = 2;
				end
				default: begin
					len_raw = $urandom_range(31);
					tmo_raw = ($urandom_range(3) == 0) ? $urandom_range(255)
						: $urandom_range(12);
				end
			endcase
			for (i = 0; i < 8; i++) begin
				lo[8*i +: 8] = gen_pat[i];
				hi[8*i +: 8] = gen_pat[i + 8];
			end
			write_reg(REG_PAT_LO, lo);
			write_reg(REG_PAT_HI, hi);
			write_reg(REG_PAT_LEN, 64'(len_raw));
			write_reg(REG_TIMEOUT, 64'(tmo_raw));
			gen_len = (len_raw == 0) ? 1 : ((len_raw > LEN_CAP) ? LEN_CAP : len_raw);
			gen_tmo = tmo_raw;
			round_start = items_sent;
			if (r == 3) begin
				add_item(KIND_ARM, 8'h00);
				add_item(KIND_BYTE, 8'h41);
				repeat (255) add_item(KIND_TICK, 8'($urandom_range(255)));
			end
			while (items_sent - round_start < ROUND_ITEMS)
				add_wait_sequence();
		end
		wait_idle();

		$display("Sent %0d items over %0d pattern/timeout settings", items_sent, NUM_ROUNDS + 1);
		$display("Observed %0d matches and %0d timeouts, %0d mismatches",
			matches_seen, timeouts_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/spwt_pkg.sv
hdl/spwt_front.sv
hdl/spwt_queue.sv
hdl/spwt_back.sv
hdl/serial_pattern_wait_with_timeout_core.sv
tb/serial_pattern_wait_with_timeout_core_tb.sv
